FILE: src/mfbp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the msb first bit packer
// no dependencies
package mfbp_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_ALIGN  = 2'd1,
    OP_PREFIX = 2'd2
  } op_t;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PendW    = 7;
  localparam int unsigned CntW     = 3;
  localparam int unsigned LenW     = 16;
  localparam int unsigned InDataW  = 32;
  localparam logic [7:0]  ShortFlag  = 8'h80;
  localparam logic [15:0] ShortLimit = 16'd128;
  localparam logic [3:0]  MaxCount   = 4'd8;

  typedef struct packed {
    logic [1:0]       nres;
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;
    logic [PendW-1:0] pend_bits;
    logic [CntW-1:0]  pend_count;
  } res_t;

endpackage

FILE: src/mfbp_core.sv
`timescale 1ns / 1ps
// combinational packing step: one item against the pending partial byte
// depends on mfbp_pkg
module mfbp_core (
  input  logic [1:0]                  opcode,
  input  logic [7:0]                  data_bits,
  input  logic [3:0]                  bit_count,
  input  logic [15:0]                 length_value,
  input  logic [mfbp_pkg::PendW-1:0]  pend_bits,
  input  logic [mfbp_pkg::CntW-1:0]   pend_count,
  output mfbp_pkg::res_t              res
);

  logic [4:0]  n;
  logic [15:0] v;
  logic [7:0]  mask8;
  logic [3:0]  nsat;
  logic [23:0] comb;
  logic [4:0]  total;
  logic [4:0]  rem;

  assign nsat  = (bit_count > mfbp_pkg::MaxCount) ? mfbp_pkg::MaxCount : bit_count;
  assign mask8 = ~(8'hFF << nsat);

  always_comb begin
    n = 5'd0;
    v = 16'd0;
    unique case (mfbp_pkg::op_t'(opcode))
      mfbp_pkg::OP_APPEND: begin
        n = {1'b0, nsat};
        v = {8'd0, data_bits & mask8};
      end
      mfbp_pkg::OP_ALIGN: begin
        n = (pend_count == 3'd0) ? 5'd0 : 5'd8 - {2'b00, pend_count};
        v = 16'd0;
      end
      mfbp_pkg::OP_PREFIX: begin
        if (length_value < mfbp_pkg::ShortLimit) begin
          n = 5'd8;
          v = {8'd0, mfbp_pkg::ShortFlag | {1'b0, length_value[6:0]}};
        end else begin
          n = 5'd16;
          v = length_value;
        end
      end
      default: begin
        n = 5'd0;
        v = 16'd0;
      end
    endcase
  end

  assign comb  = ({17'd0, pend_bits} << n) | {8'd0, v};
  assign total = {2'b00, pend_count} + n;

  always_comb begin
    res.b0 = 8'd0;
    res.b1 = 8'd0;
    if (total >= 5'd16) begin
      res.nres = 2'd2;
      res.b0   = 8'(comb >> (total - 5'd8));
      res.b1   = 8'(comb >> (total - 5'd16));
      rem      = total - 5'd16;
    end else if (total >= 5'd8) begin
      res.nres = 2'd1;
      res.b0   = 8'(comb >> (total - 5'd8));
      rem      = total - 5'd8;
    end else begin
      res.nres = 2'd0;
      rem      = total;
    end
    res.pend_bits  = 7'(comb & ~(24'hFFFFFF << rem));
    res.pend_count = 3'(rem);
  end

endmodule

FILE: src/mfbp_out_buf.sv
`timescale 1ns / 1ps
// two-entry result register that hands out the bytes of one item in order
// depends on mfbp_pkg
module mfbp_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  mfbp_pkg::res_t       res,
  output logic                 free,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // out_byte
  output logic                 m_tlast    // last_of_run
);

  logic [1:0] ocnt;
  logic [7:0] ob0;
  logic [7:0] ob1;
  logic       pop;

  assign m_tvalid = (ocnt != 2'd0);
  assign m_tdata  = ob0;
  assign m_tlast  = (ocnt == 2'd1);
  assign pop      = m_tvalid && m_tready;
  assign free     = (ocnt == 2'd0) || ((ocnt == 2'd1) && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 2'd0;
    end else if (load) begin
      ocnt <= res.nres;
    end else if (pop) begin
      ocnt <= ocnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ob0 <= res.b0;
      ob1 <= res.b1;
    end else if (pop) begin
      ob0 <= ob1;
    end
  end

`ifndef SYNTHESIS
  a_ocnt_range: assert property (@(posedge clk) disable iff (rst)
    ocnt != 2'd3) else $error("result count out of range");
  a_two_byte_load: assert property (@(posedge clk) disable iff (rst)
    load && res.nres == 2'd2 |=> m_tvalid && !m_tlast)
    else $error("first of two bytes flagged last");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> free) else $error("result register overwritten");
`endif

endmodule

FILE: src/msb_first_bit_packer_unit.sv
`timescale 1ns / 1ps
// msb first bit packer: input register, packing step, result register
// depends on mfbp_pkg, mfbp_core, mfbp_out_buf
//
// usage
// s_tdata carries one command item: opcode, data_bits, bit_count and
// length_value. append opcode adds 0 to 8 bits, align pads to the next
// byte, prefix writes a one or two byte length. m_tdata carries the
// completed bytes, first stream bit in bit 7; m_tlast marks the final
// byte caused by an item. items that complete no byte emit nothing.
// an accepted item is held in the input register, then its bytes are
// registered in the result register, from which the first goes out on
// m_tdata.
// throughput: one item per cycle while m_tready stays high; after a two
// byte length prefix, a following item that completes a byte waits while
// the second byte drains.
// reset clears the partial byte, its bit count and the valid state of both registers.
// when the receiver stalls, bytes hold in the result register and
// s_tready drops once the input register cannot advance.
module msb_first_bit_packer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // opcode, data_bits, bit_count, length_value, zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte
  output logic        m_tlast    // last_of_run
);

  logic                        iv;
  logic [1:0]                  i_opcode;
  logic [7:0]                  i_data;
  logic [3:0]                  i_count;
  logic [15:0]                 i_len;
  logic [mfbp_pkg::PendW-1:0]  pend_bits;
  logic [mfbp_pkg::CntW-1:0]   pend_count;
  mfbp_pkg::res_t              res;
  logic                        free;
  logic                        advance;
  logic                        load;

  mfbp_core u_core (
    .opcode       (i_opcode),
    .data_bits    (i_data),
    .bit_count    (i_count),
    .length_value (i_len),
    .pend_bits    (pend_bits),
    .pend_count   (pend_count),
    .res          (res)
  );

  assign advance  = iv && ((res.nres == 2'd0) || free);
  assign load     = advance && (res.nres != 2'd0);
  assign s_tready = !iv || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (s_tready) begin
      iv <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      i_opcode <= s_tdata[1:0];
      i_data   <= s_tdata[9:2];
      i_count  <= s_tdata[13:10];
      i_len    <= s_tdata[29:14];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits  <= '0;
      pend_count <= '0;
    end else if (advance) begin
      pend_bits  <= res.pend_bits;
      pend_count <= res.pend_count;
    end
  end

  mfbp_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .res      (res),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTHESIS
  a_align_clears: assert property (@(posedge clk) disable iff (rst)
    advance && i_opcode == mfbp_pkg::OP_ALIGN |=> pend_count == '0)
    else $error("align left partial bits");
  a_prefix_keeps_count: assert property (@(posedge clk) disable iff (rst)
    advance && i_opcode == mfbp_pkg::OP_PREFIX |=> pend_count == $past(pend_count))
    else $error("prefix changed bit position");
`endif

endmodule
